// ===== design/llab_pkg.sv =====
// Shared types, constants and helpers for the linearized alpha blend block.
// No dependencies; used by llab_front, llab_queue, llab_back and the top level.
package llab_pkg;

   localparam int OUT_INDEX_BITS = 16;
   localparam int OUT_DEPTH      = 1 << OUT_INDEX_BITS;
   localparam int FWD_TABLES     = 8;
   localparam int FWD_DEPTH      = 256;
   localparam int LANES          = 4;
   // power of two so the pointers wrap by themselves
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // request operation codes
   localparam logic [1:0] OP_BLEND     = 2'd0;
   localparam logic [1:0] OP_FWD_WRITE = 2'd1;
   localparam logic [1:0] OP_OUT_WRITE = 2'd2;

   typedef enum logic {
      KIND_BLEND,
      KIND_OUT_WRITE
   } kind_type;

   typedef struct packed {
      kind_type                        kind;
      logic [7:0]                      alpha;
      logic [LANES-1:0][15:0]          src_lanes;
      logic [LANES-1:0][15:0]          dst_lanes;
      logic [1:0]                      out_channel;
      logic [OUT_INDEX_BITS-1:0]       out_addr;
      logic [7:0]                      out_data;
   } queue_entry_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   // signed 16-bit add with saturation
   function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] sum;
      sum = {a[15], a} + {b[15], b};
      if (sum[16] != sum[15]) begin
         sat_add16 = sum[16] ? 16'h8000 : 16'h7FFF;
      end else begin
         sat_add16 = sum[15:0];
      end
   endfunction

endpackage

// ===== design/llab_front.sv =====
// Front end: accepts requests, owns the eight forward tables, linearizes pixels.
// Depends on llab_pkg; feeds llab_queue.
module llab_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_operation,
   input  logic [31:0]                req_source_pixel,
   input  logic [31:0]                req_dest_pixel,
   input  logic [17:0]                req_table_index,
   input  logic [63:0]                req_table_data,
   input  llab_pkg::queue_status_type q_status,
   output logic                       q_push,
   output llab_pkg::queue_entry_type  q_data
);

   logic                                 accept;
   logic                                 fwd_wr;
   logic                                 rd_en;
   logic                                 needs_queue;
   logic                                 s1_valid_ff;
   logic                                 s1_valid_in;
   llab_pkg::kind_type                   s1_kind_ff;
   logic [7:0]                           s1_alpha_ff;
   logic [1:0]                           s1_channel_ff;
   logic [llab_pkg::OUT_INDEX_BITS-1:0]  s1_addr_ff;
   logic [7:0]                           s1_data_ff;
   logic [63:0]                          fwd_word [llab_pkg::FWD_TABLES];
   logic [llab_pkg::LANES-1:0][15:0]     src_sum;
   logic [llab_pkg::LANES-1:0][15:0]     dst_sum;

   assign accept    = req_valid && req_ready;
   assign req_ready = !s1_valid_ff || !q_status.full;
   assign q_push    = s1_valid_ff && !q_status.full;

   // forward writes beyond the 2048 entries are dropped
   assign fwd_wr = accept && (req_operation == llab_pkg::OP_FWD_WRITE)
                   && (req_table_index[17:11] == 7'd0);
   assign rd_en  = accept && (req_operation == llab_pkg::OP_BLEND);
   assign needs_queue = (req_operation == llab_pkg::OP_BLEND)
                        || (req_operation == llab_pkg::OP_OUT_WRITE);

   // one 256-entry table per pixel byte: tables 0-3 source, 4-7 destination,
   // bytes 2, 1, 0, 3 in that order
   for (genvar t = 0; t < llab_pkg::FWD_TABLES; t++) begin : g_fwd
      localparam int LANE_POS = t % 4;
      localparam int BYTE_SEL = (LANE_POS == 3) ? 3 : (2 - LANE_POS);
      logic [63:0] mem [llab_pkg::FWD_DEPTH];
      logic [63:0] word_ff;
      logic [31:0] pixel;
      logic [7:0]  rd_addr;

      assign pixel   = (t < 4) ? req_source_pixel : req_dest_pixel;
      assign rd_addr = pixel[8*BYTE_SEL +: 8];

      always_ff @(posedge clock) begin
         if (fwd_wr && (req_table_index[10:8] == 3'(t))) begin
            mem[req_table_index[7:0]] <= req_table_data;
         end
         if (rd_en) begin
            word_ff <= mem[rd_addr];
         end
      end

      assign fwd_word[t] = word_ff;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = needs_queue;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff    <= (req_operation == llab_pkg::OP_BLEND) ? llab_pkg::KIND_BLEND
                                                                : llab_pkg::KIND_OUT_WRITE;
         s1_alpha_ff   <= req_source_pixel[31:24];
         s1_channel_ff <= req_table_index[17:16];
         s1_addr_ff    <= req_table_index[llab_pkg::OUT_INDEX_BITS-1:0];
         s1_data_ff    <= req_table_data[7:0];
      end
   end

   // saturating sum of four words per lane, three dependent adds
   always_comb begin
      for (int k = 0; k < llab_pkg::LANES; k++) begin
         src_sum[k] = fwd_word[0][16*k +: 16];
         dst_sum[k] = fwd_word[4][16*k +: 16];
         for (int t = 1; t < 4; t++) begin
            src_sum[k] = llab_pkg::sat_add16(src_sum[k], fwd_word[t][16*k +: 16]);
            dst_sum[k] = llab_pkg::sat_add16(dst_sum[k], fwd_word[t+4][16*k +: 16]);
         end
      end
   end

   always_comb begin
      q_data.kind        = s1_kind_ff;
      q_data.alpha       = s1_alpha_ff;
      q_data.src_lanes   = src_sum;
      q_data.dst_lanes   = dst_sum;
      q_data.out_channel = s1_channel_ff;
      q_data.out_addr    = s1_addr_ff;
      q_data.out_data    = s1_data_ff;
   end

endmodule

// ===== design/llab_queue.sv =====
// Small register FIFO between front and back ends.
// Depends on llab_pkg.
module llab_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  llab_pkg::queue_entry_type  push_data,
   input  logic                       pop,
   output llab_pkg::queue_entry_type  pop_data,
   output llab_pkg::queue_status_type status
);

   localparam int PTR = llab_pkg::QUEUE_PTR_BITS;

   llab_pkg::queue_entry_type mem [llab_pkg::QUEUE_DEPTH];
   logic [PTR-1:0] wr_ptr_ff;
   logic [PTR-1:0] wr_ptr_in;
   logic [PTR-1:0] rd_ptr_ff;
   logic [PTR-1:0] rd_ptr_in;
   logic [PTR:0]   count_ff;
   logic [PTR:0]   count_in;

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == (PTR+1)'(llab_pkg::QUEUE_DEPTH));
   assign pop_data     = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/llab_back.sv =====
// Back end: alpha scaling, final saturating add, output byte tables, result register.
// Depends on llab_pkg; drains llab_queue.
module llab_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       premultiplied_mode,
   input  llab_pkg::queue_status_type q_status,
   input  llab_pkg::queue_entry_type  q_data,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [31:0]                rsp_blended_pixel
);

   logic                                 b1_valid_ff;
   logic                                 b1_valid_in;
   logic                                 b1_adv;
   llab_pkg::kind_type                   b1_kind_ff;
   logic [llab_pkg::LANES-1:0][15:0]     b1_src_ff;
   logic [llab_pkg::LANES-1:0][15:0]     b1_dst_ff;
   logic [1:0]                           b1_channel_ff;
   logic [llab_pkg::OUT_INDEX_BITS-1:0]  b1_addr_ff;
   logic [7:0]                           b1_data_ff;
   logic [llab_pkg::LANES-1:0][15:0]     src_scaled_in;
   logic [llab_pkg::LANES-1:0][15:0]     dst_scaled_in;
   logic [15:0]                          factor;
   logic [15:0]                          factor_inv;
   logic [31:0]                          prod_src [llab_pkg::LANES];
   logic [31:0]                          prod_dst [llab_pkg::LANES];
   logic [15:0]                          lane_sum [llab_pkg::LANES];
   logic [llab_pkg::OUT_INDEX_BITS-1:0]  out_pos  [llab_pkg::LANES];
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic                                 rd_en;
   logic                                 wr_en;

   // table writes never wait on the result register
   assign b1_adv = b1_valid_ff && ((b1_kind_ff == llab_pkg::KIND_OUT_WRITE)
                                   || !rsp_valid_ff || rsp_ready);
   assign q_pop  = q_status.valid && (!b1_valid_ff || b1_adv);
   assign rd_en  = b1_adv && (b1_kind_ff == llab_pkg::KIND_BLEND);
   assign wr_en  = b1_adv && (b1_kind_ff == llab_pkg::KIND_OUT_WRITE);

   // alpha*257 is the alpha byte repeated; 65535 minus it is its complement
   assign factor     = {q_data.alpha, q_data.alpha};
   assign factor_inv = ~factor;

   always_comb begin
      for (int k = 0; k < llab_pkg::LANES; k++) begin
         prod_src[k]      = {16'd0, q_data.src_lanes[k]} * {16'd0, factor};
         prod_dst[k]      = {16'd0, q_data.dst_lanes[k]} * {16'd0, factor_inv};
         src_scaled_in[k] = premultiplied_mode ? q_data.src_lanes[k] : prod_src[k][31:16];
         dst_scaled_in[k] = prod_dst[k][31:16];
      end
   end

   always_comb begin
      b1_valid_in = b1_valid_ff;
      if (q_pop) begin
         b1_valid_in = 1'b1;
      end else if (b1_adv) begin
         b1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rd_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b1_kind_ff    <= q_data.kind;
         b1_src_ff     <= src_scaled_in;
         b1_dst_ff     <= dst_scaled_in;
         b1_channel_ff <= q_data.out_channel;
         b1_addr_ff    <= q_data.out_addr;
         b1_data_ff    <= q_data.out_data;
      end
   end

   // lane index: top bits of the saturated unsigned lane value
   always_comb begin
      for (int c = 0; c < llab_pkg::LANES; c++) begin
         lane_sum[c] = llab_pkg::sat_add16(b1_dst_ff[c], b1_src_ff[c]);
         out_pos[c]  = lane_sum[c][15 -: llab_pkg::OUT_INDEX_BITS];
      end
   end

   for (genvar c = 0; c < llab_pkg::LANES; c++) begin : g_out
      logic [7:0] mem [llab_pkg::OUT_DEPTH];
      logic [7:0] pix_ff;

      always_ff @(posedge clock) begin
         if (wr_en && (b1_channel_ff == 2'(c))) begin
            mem[b1_addr_ff] <= b1_data_ff;
         end
         if (rd_en) begin
            pix_ff <= mem[out_pos[c]];
         end
      end

      assign rsp_blended_pixel[8*c +: 8] = pix_ff;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/lut_linearized_alpha_blend.sv =====
// Top level of the table-linearized ARGB8888 alpha blender.
// Depends on llab_pkg, llab_front, llab_queue and llab_back.

// Blends a source pixel over a destination pixel through lookup tables and
// sustains one request per clock while the queue has room: blends and table writes
// alike are taken back to back; a blend result reaches rsp_valid via the
// front-end, queue, back-end and result registers. Table ports set the rate:
// each of the eight forward tables (256 x 64) and each of the four output
// channel tables (2^16 x 8) is its own memory with one read and one write
// port, so every pixel byte and every lane finds its table in the same cycle.
// Pipeline: the front end registers the request together with the eight
// forward-table reads, sums the words per lane with 16-bit saturation and
// pushes blends and output-table writes into a four-entry queue; forward-table
// writes and operation code 3 finish in the front end and leave nothing
// behind. The back end pops the queue, scales the lanes by alpha and its
// complement (eight 16x16 multipliers, registered), adds with saturation,
// reads the output tables and holds the pixel in the result register, so a
// stalled response consumer backs up the queue. Table writes take effect
// in request order relative to blends. Tables come out of reset unwritten and
// must be loaded before a blend reads them; there is no clearing pass.
// csr_write_data sets premultiplied mode (source lanes used unscaled) and may
// be written only while the block is idle.
module lut_linearized_alpha_blend (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_source_pixel,
   input  logic [31:0] req_dest_pixel,
   input  logic [17:0] req_table_index,
   input  logic [63:0] req_table_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_blended_pixel,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   logic                       premult_ff;
   logic                       premult_in;
   logic                       q_push;
   logic                       q_pop;
   llab_pkg::queue_entry_type  q_push_data;
   llab_pkg::queue_entry_type  q_pop_data;
   llab_pkg::queue_status_type q_status;

   // configuration register
   assign premult_in = csr_write_enable ? csr_write_data : premult_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         premult_ff <= 1'b0;
      end else begin
         premult_ff <= premult_in;
      end
   end

   // request side: decode, forward tables, linearization
   llab_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_source_pixel (req_source_pixel),
      .req_dest_pixel   (req_dest_pixel),
      .req_table_index  (req_table_index),
      .req_table_data   (req_table_data),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_data           (q_push_data)
   );

   // decouples the two halves so each can stall on its own
   llab_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // response side: scaling, output tables, result register
   llab_back u_back (
      .clock              (clock),
      .reset              (reset),
      .premultiplied_mode (premult_ff),
      .q_status           (q_status),
      .q_data             (q_pop_data),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_blended_pixel  (rsp_blended_pixel)
   );

   // the front end only stalls requests on a full queue
   a_ready_only_on_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_status.full)
      else $error("request stalled while queue has room");

   // a full queue stays full until the back end drains an entry
   a_full_holds : assert property (@(posedge clock) disable iff (reset)
      q_status.full && !q_pop |=> q_status.full)
      else $error("queue left full state without a pop");

   a_full_is_valid : assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> q_status.valid)
      else $error("queue full but reports no entry");

   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_status.valid)
      else $error("back end popped an empty queue");

endmodule

// ===== tb/sv/tb_lut_linearized_alpha_blend.sv =====
// Self-checking testbench for lut_linearized_alpha_blend: table loads, blends and
// premultiplied mode, checked transfer by transfer against a predictor of its own.
// Depends on llab_pkg and the lut_linearized_alpha_blend RTL.
module tb_lut_linearized_alpha_blend;

   // op code 3 has no meaning in the block; it must pass through silently
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int FWD_WORDS       = llab_pkg::FWD_TABLES * llab_pkg::FWD_DEPTH;
   localparam int OUT_BYTES       = llab_pkg::LANES * llab_pkg::OUT_DEPTH;
   // pipeline is three deep plus a four-entry queue; leave margin
   localparam int DRAIN_CYCLES    = 16;
   localparam int RSP_HOLD_CYCLES = 250;
   // roughly 1300 transfers; sparse receiver, sender gaps and drains stay far below
   localparam int CYCLE_LIMIT     = 200_000;
   localparam int MAX_REPORTS     = 10;
   localparam int PHASE_ITEMS     = 60;
   localparam int PRESSURE_ITEMS  = 30;

   typedef enum logic [1:0] {
      RSP_STEADY,
      RSP_COIN,
      RSP_SPARSE,
      RSP_PERIODIC
   } rsp_pattern_type;

   // every block input is known from time zero
   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation      = llab_pkg::OP_BLEND;
   logic [31:0] req_source_pixel   = '0;
   logic [31:0] req_dest_pixel     = '0;
   logic [17:0] req_table_index    = '0;
   logic [63:0] req_table_data     = '0;
   logic        rsp_valid;
   logic        rsp_ready          = 1'b0;
   logic [31:0] rsp_blended_pixel;
   logic        csr_write_enable   = 1'b0;
   logic        csr_write_data     = 1'b0;

   // predictor state: shadow copies of both table sets and the mode bit
   logic [63:0] fwd_words [0:FWD_WORDS-1];
   logic [7:0]  out_bytes [0:OUT_BYTES-1];
   // entries loaded so far; a blend only ever reads loaded entries
   bit          fwd_written [0:FWD_WORDS-1];
   bit          out_written [0:OUT_BYTES-1];
   logic        premult_mode = 1'b0;
   logic [31:0] expected_pixels [$];

   int              mismatch_count = 0;
   int              cycle_count    = 0;
   // sender burst/gap control
   int              burst_left     = 0;
   bit              sender_idles   = 1'b1;
   // receiver: long hold requests from the test sequence, served in its own process
   int              holds_asked    = 0;
   int              holds_served   = 0;
   int              hold_left      = 0;
   rsp_pattern_type rsp_pattern    = RSP_STEADY;
   int              pattern_left   = 0;

   lut_linearized_alpha_blend i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_source_pixel  (req_source_pixel),
      .req_dest_pixel    (req_dest_pixel),
      .req_table_index   (req_table_index),
      .req_table_data    (req_table_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_blended_pixel (rsp_blended_pixel),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   function automatic logic [15:0] sat16(input int v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   // high half of the unsigned 16x16 product
   function automatic logic [15:0] scale_high(input logic [15:0] lane, input logic [15:0] f);
      logic [31:0] p;
      p = lane * f;
      return p[31:16];
   endfunction

   // forward-table slot read for table t (0-3 source, 4-7 destination)
   function automatic int fwd_slot(input logic [31:0] src, input logic [31:0] dst,
                                   input int t);
      logic [31:0] pixel;
      int          sel;
      sel   = (t % 4 == 3) ? 3 : 2 - t % 4;
      pixel = (t < 4) ? src : dst;
      return t * llab_pkg::FWD_DEPTH + int'(pixel[8*sel +: 8]);
   endfunction

   // sum of four forward words, picked by pixel bytes 2, 1, 0, 3, per lane with
   // signed saturation; base is table 0 for source, 4 for destination
   function automatic logic [63:0] linear_lanes(input logic [31:0] pixel, input int base);
      logic [63:0] acc;
      logic [63:0] word;
      logic [7:0]  b;
      shortint     x;
      shortint     y;
      int          t;
      int          k;
      int          sel;
      int          sum;
      acc = '0;
      for (t = 0; t < 4; t++) begin
         sel  = (t == 3) ? 3 : 2 - t;
         b    = pixel[8*sel +: 8];
         word = fwd_words[(base + t) * llab_pkg::FWD_DEPTH + int'(b)];
         for (k = 0; k < llab_pkg::LANES; k++) begin
            x   = acc[16*k +: 16];
            y   = word[16*k +: 16];
            sum = x + y;
            acc[16*k +: 16] = sat16(sum);
         end
      end
      return acc;
   endfunction

   // per-lane output-table position of a blend under the current shadow state
   function automatic logic [63:0] blend_positions(input logic [31:0] src,
                                                   input logic [31:0] dst);
      logic [63:0] s_lanes;
      logic [63:0] d_lanes;
      logic [63:0] pos;
      logic [15:0] a;
      logic [15:0] a_inv;
      logic [15:0] sv;
      logic [15:0] dv;
      logic [15:0] r;
      shortint     s16;
      shortint     d16;
      int          sum;
      int          k;
      s_lanes = linear_lanes(src, 0);
      d_lanes = linear_lanes(dst, 4);
      a       = src[31:24] * 16'd257;     // alpha always from the source pixel
      a_inv   = 16'hFFFF - a;
      for (k = 0; k < llab_pkg::LANES; k++) begin
         sv  = premult_mode ? s_lanes[16*k +: 16] : scale_high(s_lanes[16*k +: 16], a);
         dv  = scale_high(d_lanes[16*k +: 16], a_inv);
         s16 = sv;
         d16 = dv;
         sum = s16 + d16;
         r   = sat16(sum);
         // lane read as unsigned, top OUT_INDEX_BITS bits pick the channel's entry
         pos[16*k +: 16] = r >> (16 - llab_pkg::OUT_INDEX_BITS);
      end
      return pos;
   endfunction

   function automatic logic [31:0] blend_pixel(input logic [63:0] pos);
      logic [31:0] pixel;
      int          k;
      for (k = 0; k < llab_pkg::LANES; k++)
         pixel[8*k +: 8] = out_bytes[k * llab_pkg::OUT_DEPTH + int'(pos[16*k +: 16])];
      return pixel;
   endfunction

   // apply one accepted request to the shadow state, queue its pixel if any
   function automatic void model_request(input logic [1:0] op, input logic [31:0] src,
                                         input logic [31:0] dst, input logic [17:0] idx,
                                         input logic [63:0] data);
      int slot;
      case (op)
         llab_pkg::OP_BLEND: begin
            expected_pixels.push_back(blend_pixel(blend_positions(src, dst)));
         end
         llab_pkg::OP_FWD_WRITE: begin
            // out-of-range index: write dropped
            if (idx < FWD_WORDS) begin
               fwd_words[idx]   = data;
               fwd_written[idx] = 1'b1;
            end
         end
         llab_pkg::OP_OUT_WRITE: begin
            slot = int'(idx[17:16]) * llab_pkg::OUT_DEPTH
                   + int'(idx[llab_pkg::OUT_INDEX_BITS-1:0]);
            out_bytes[slot]   = data[7:0];
            out_written[slot] = 1'b1;
         end
         default: begin
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic logic [63:0] random_fwd_word();
      logic [63:0] w;
      int          k;
      for (k = 0; k < llab_pkg::LANES; k++) begin
         case ($urandom_range(0, 7))
            0:          w[16*k +: 16] = 16'h7FFF;
            1:          w[16*k +: 16] = 16'h8000;
            2, 3, 4, 5: w[16*k +: 16] = 16'($urandom_range(0, 4095) - 2048);
            default:    w[16*k +: 16] = 16'($urandom);
         endcase
      end
      return w;
   endfunction

   // pixel bytes from a small set so the forward tables fill quickly
   function automatic logic [31:0] random_pixel();
      logic [31:0] p;
      int          k;
      for (k = 0; k < 4; k++) begin
         case ($urandom_range(0, 7))
            0:       p[8*k +: 8] = 8'h00;
            1:       p[8*k +: 8] = 8'hFF;
            default: p[8*k +: 8] = {5'($urandom_range(0, 31)), 3'd0};
         endcase
      end
      return p;
   endfunction

   // One request transfer. Sender runs in bursts; between bursts it may drop
   // valid for a few cycles. Valid holds with a stable payload until accepted.
   task automatic send_item(input logic [1:0] op, input logic [31:0] src,
                            input logic [31:0] dst, input logic [17:0] idx,
                            input logic [63:0] data);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_idles ? $urandom_range(0, 7) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_source_pixel <= src;
      req_dest_pixel   <= dst;
      req_table_index  <= idx;
      req_table_data   <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model_request(op, src, dst, idx, data);
   endtask

   // Tables reset undefined: every entry a blend reads is loaded first, forward
   // words before the output bytes their sums land on, then the blend goes out.
   task automatic send_blend(input logic [31:0] src, input logic [31:0] dst);
      logic [63:0] pos;
      int          t;
      int          k;
      int          slot;
      for (t = 0; t < llab_pkg::FWD_TABLES; t++) begin
         slot = fwd_slot(src, dst, t);
         if (!fwd_written[slot])
            send_item(llab_pkg::OP_FWD_WRITE, $urandom, $urandom, 18'(slot),
                      random_fwd_word());
      end
      pos = blend_positions(src, dst);
      for (k = 0; k < llab_pkg::LANES; k++) begin
         slot = k * llab_pkg::OUT_DEPTH + int'(pos[16*k +: 16]);
         if (!out_written[slot])
            send_item(llab_pkg::OP_OUT_WRITE, $urandom, $urandom,
                      {2'(k), pos[16*k +: 16]}, {$urandom, $urandom});
      end
      send_item(llab_pkg::OP_BLEND, src, dst, 18'($urandom), {$urandom, $urandom});
   endtask

   // blend_pct: share of blends; the rest splits over the three other ops
   task automatic send_random_item(input int blend_pct);
      logic [31:0] src;
      logic [17:0] idx;
      int          pick;
      int          alpha_pick;
      src  = random_pixel();
      pick = $urandom_range(0, 99);
      if (pick < blend_pct) begin
         // bias alpha toward fully transparent and fully opaque
         alpha_pick = $urandom_range(0, 3);
         if (alpha_pick == 0) src[31:24] = 8'h00;
         else if (alpha_pick == 1) src[31:24] = 8'hFF;
         send_blend(src, random_pixel());
      end else if (pick < blend_pct + (100 - blend_pct) * 45 / 100) begin
         idx = ($urandom_range(0, 9) == 0) ? 18'($urandom_range(FWD_WORDS, 262143))
                                           : 18'($urandom_range(0, FWD_WORDS - 1));
         send_item(llab_pkg::OP_FWD_WRITE, src, $urandom, idx, random_fwd_word());
      end else if (pick < blend_pct + (100 - blend_pct) * 85 / 100) begin
         send_item(llab_pkg::OP_OUT_WRITE, src, $urandom, 18'($urandom_range(0, 262143)),
                   {$urandom, $urandom});
      end else begin
         send_item(OP_UNUSED, src, $urandom, 18'($urandom), {$urandom, $urandom});
      end
   endtask

   // wait until every pixel is back, then let trailing table writes settle
   task automatic drain_block();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_premultiplied(input logic mode);
      drain_block();
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      premult_mode = mode;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Saturation at both ends, alpha extremes, both modes, dropped writes, op 3.
   task automatic test_directed_cases();
      int t;
      write_premultiplied(1'b0);
      // source tables at byte FF go to +max, destination tables at byte 00 to -max
      for (t = 0; t < 4; t++)
         send_item(llab_pkg::OP_FWD_WRITE, '0, '0, 18'(t * llab_pkg::FWD_DEPTH + 255),
                   {4{16'h7FFF}});
      for (t = 4; t < 8; t++)
         send_item(llab_pkg::OP_FWD_WRITE, '0, '0, 18'(t * llab_pkg::FWD_DEPTH),
                   {4{16'h8000}});
      // output entries that saturated lanes land on
      send_item(llab_pkg::OP_OUT_WRITE, '0, '0, {2'd0, 16'h7FFF}, 64'h5A);
      send_item(llab_pkg::OP_OUT_WRITE, '0, '0, {2'd3, 16'h7FFF}, 64'hFFFF_FFFF_FFFF_FFC3);
      send_item(llab_pkg::OP_OUT_WRITE, '0, '0, {2'd3, 16'hFFFF}, 64'h81);
      send_item(llab_pkg::OP_OUT_WRITE, '0, '0, {2'd1, 16'h0000}, 64'h7E);
      // out-of-range forward writes must not alias onto table 0
      send_item(llab_pkg::OP_FWD_WRITE, '0, '0, 18'(FWD_WORDS), '1);
      send_item(llab_pkg::OP_FWD_WRITE, '0, '0, 18'h3FFFF, '1);
      send_item(OP_UNUSED, '1, '1, '1, '1);
      send_blend(32'hFFFF_FFFF, 32'h0000_0000);
      send_blend(32'h00FF_FFFF, 32'h0000_0000);
      send_blend(32'h80FF_FFFF, 32'hFFFF_FFFF);
      send_blend(32'h0000_0000, 32'hFFFF_FFFF);
      write_premultiplied(1'b1);
      send_blend(32'hFFFF_FFFF, 32'h0000_0000);
      send_blend(32'h0000_0000, 32'h0000_0000);
   endtask

   // Mixed random traffic in four phases, mode toggled between them; the
   // third phase runs the sender without gaps.
   task automatic test_random_traffic();
      int phase;
      int i;
      for (phase = 0; phase < 4; phase++) begin
         write_premultiplied(phase % 2 == 0);
         sender_idles = (phase != 2);
         for (i = 0; i < PHASE_ITEMS; i++) send_random_item(65);
      end
      sender_idles = 1'b1;
   endtask

   // Receiver holds off for a long stretch while blends keep coming, so the
   // queue fills and req_ready must drop; then everything drains in order.
   task automatic test_input_backpressure();
      int i;
      drain_block();
      holds_asked++;
      while (hold_left == 0) @(posedge clock);
      sender_idles = 1'b0;
      for (i = 0; i < PRESSURE_ITEMS; i++) send_random_item(100);
      sender_idles = 1'b1;
   endtask

   // ---------------------------------------------------------------------------
   // Receiver: random ready patterns, plus the long hold on request
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_served + 1;
         hold_left    <= RSP_HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            rsp_pattern  <= rsp_pattern_type'($urandom_range(0, 3));
            pattern_left <= $urandom_range(16, 96);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (rsp_pattern)
            RSP_STEADY: rsp_ready <= 1'b1;
            RSP_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RSP_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:    rsp_ready <= cycle_count[2];
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Result checker: each response transfer against the oldest expected pixel
   // ---------------------------------------------------------------------------
   function automatic void note_mismatch(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("ERROR cycle %0d: %s blended_pixel expected %08h got %08h",
                  cycle_count, what, want, got);
   endfunction

   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            note_mismatch("unexpected transfer,", 'x, rsp_blended_pixel);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_blended_pixel !== want) note_mismatch("wrong", want, rsp_blended_pixel);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles, %0d pixels outstanding",
                  cycle_count, expected_pixels.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic();
      test_input_backpressure();
      drain_block();
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
